// ===== design/bbc_pkg.sv =====
// Package for the block buffer cache directory.
// Holds slot count, reference count width, status codes and the result type.
// Used by every module of the block; depends on nothing.
package bbc_pkg;

  localparam int NUM_SLOTS = 16;
  localparam int REF_BITS  = 8;
  localparam int IDX_W     = $clog2(NUM_SLOTS);

  localparam logic [REF_BITS-1:0] REF_MAX  = {REF_BITS{1'b1}};
  localparam logic [REF_BITS-1:0] REF_ONE  = REF_BITS'(1);
  localparam logic [REF_BITS-1:0] REF_ZERO = '0;

  localparam logic [1:0] REQ_GET  = 2'd0;
  localparam logic [1:0] REQ_PUT  = 2'd1;
  localparam logic [1:0] REQ_FREE = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_BUF    = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [1:0] ST_OVERFLOW  = 2'd3;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  slot_out;
    logic        hit;
    logic        need_page;
    logic        need_read;
    logic [4:0]  drop_count;
    logic [15:0] freed_mask;
  } result_t;

endpackage

// ===== design/block_buffer_cache_lru_top.sv =====
// Top level of the block buffer cache directory with LRU victim choice.
// Instantiates bbc_ctrl and holds the result register; depends on bbc_pkg.
//
// Usage: one request item enters on in_valid/in_ready: a get (block_id),
// a put (slot) or a free request (free_limit). Each item gives exactly one
// result item on out_valid/out_ready with status, slot_out, hit, need_page,
// need_read, drop_count and freed_mask.
// The block works on one item at a time; in_ready is high only while idle.
// A get walks all 16 slots through one tag compare, one slot per cycle, then
// resolves a hit or a victim; if it changes state, a recency update follows. A free
// request walks the 16 recency ranks oldest first; a put checks and updates the
// count, with a recency update if the last reference goes; an unknown request
// goes straight to its result. Another item can be taken in the cycle after the
// result is loaded.
// The result register lets the next item be accepted while a result waits.
// If the receiver stalls with a result still held, a finished item waits in
// the sequencer and no further item is taken.
// Reset clears all slot flags and counts and restores the initial recency
// order; it needs no clearing pass.
module block_buffer_cache_lru_top import bbc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [31:0] block_id,
  input  logic [3:0]  slot,
  input  logic [4:0]  free_limit,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [3:0]  slot_out,
  output logic        hit,
  output logic        need_page,
  output logic        need_read,
  output logic [4:0]  drop_count,
  output logic [15:0] freed_mask
);

  logic    idle;
  logic    res_valid;
  logic    res_ready;
  result_t res;
  result_t out_q;

  assign in_ready  = idle;
  assign res_ready = !out_valid || out_ready;

  bbc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (in_valid && in_ready),
    .idle       (idle),
    .req_type   (req_type),
    .block_id   (block_id),
    .slot       (slot),
    .free_limit (free_limit),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign status     = out_q.status;
  assign slot_out   = out_q.slot_out;
  assign hit        = out_q.hit;
  assign need_page  = out_q.need_page;
  assign need_read  = out_q.need_read;
  assign drop_count = out_q.drop_count;
  assign freed_mask = out_q.freed_mask;

endmodule

// ===== design/bbc_rank.sv =====
// Recency rank table of the buffer cache directory, zero being most recent.
// Serves one indexed rank read, one search by rank and the move-to-newest update.
// Depends on bbc_pkg.
module bbc_rank import bbc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             upd_en,
  input  logic [IDX_W-1:0] upd_slot,
  input  logic [IDX_W-1:0] rd_idx,
  output logic [IDX_W-1:0] rd_rank,
  input  logic [IDX_W-1:0] find_rank,
  output logic [IDX_W-1:0] find_slot
);

  logic [IDX_W-1:0] rank [NUM_SLOTS];
  logic [IDX_W-1:0] upd_rank;

  assign rd_rank  = rank[rd_idx];
  assign upd_rank = rank[upd_slot];

  always_comb begin
    find_slot = '0;
    for (int j = 0; j < NUM_SLOTS; j++) begin
      if (rank[j] == find_rank) begin
        find_slot = find_slot | IDX_W'(j);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < NUM_SLOTS; j++) begin
        rank[j] <= IDX_W'(NUM_SLOTS - 1 - j);
      end
    end else if (upd_en) begin
      for (int j = 0; j < NUM_SLOTS; j++) begin
        if (IDX_W'(j) == upd_slot) begin
          rank[j] <= '0;
        end else if (rank[j] < upd_rank) begin
          rank[j] <= rank[j] + 1'b1;
        end
      end
    end
  end

endmodule

// ===== design/bbc_ctrl.sv =====
// Sequencer of the buffer cache directory with the slot flags, counts and block tags.
// Walks the slots one per cycle through a shared tag compare and victim compare.
// Depends on bbc_pkg and bbc_rank.
module bbc_ctrl import bbc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        idle,
  input  logic [1:0]  req_type,
  input  logic [31:0] block_id,
  input  logic [3:0]  slot,
  input  logic [4:0]  free_limit,
  output logic        res_valid,
  input  logic        res_ready,
  output result_t     res
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SCAN    = 3'd1;
  localparam logic [2:0] S_RESOLVE = 3'd2;
  localparam logic [2:0] S_PUT     = 3'd3;
  localparam logic [2:0] S_FREE    = 3'd4;
  localparam logic [2:0] S_NEWEST  = 3'd5;
  localparam logic [2:0] S_DONE    = 3'd6;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_SLOTS - 1);

  logic [2:0]          state;
  logic [IDX_W-1:0]    idx;
  logic [31:0]         blk_q;
  logic [3:0]          slot_q;
  logic [4:0]          limit_q;
  logic                found;
  logic [IDX_W-1:0]    found_idx;
  logic                vic;
  logic [IDX_W-1:0]    vic_idx;
  logic [IDX_W-1:0]    best;
  logic [IDX_W-1:0]    nw_slot;

  logic [31:0]         tag [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] valid;
  logic [NUM_SLOTS-1:0] in_use;
  logic [NUM_SLOTS-1:0] has_page;
  logic [REF_BITS-1:0] refs [NUM_SLOTS];

  logic [IDX_W-1:0]    rd_rank;
  logic [IDX_W-1:0]    find_slot;
  logic                tag_match;
  logic                vic_better;
  logic                free_ok;
  logic [IDX_W-1:0]    put_idx;
  logic                put_bad;
  logic                wr_tag;
  logic [IDX_W-1:0]    wr_idx;

  bbc_rank u_rank (
    .clk       (clk),
    .rst       (rst),
    .upd_en    (state == S_NEWEST),
    .upd_slot  (nw_slot),
    .rd_idx    (idx),
    .rd_rank   (rd_rank),
    .find_rank (idx),
    .find_slot (find_slot)
  );

  assign tag_match  = valid[idx] && (tag[idx] == blk_q);
  assign vic_better = !in_use[idx] && (!vic || (rd_rank > best));
  assign free_ok    = (limit_q != 5'd0) && !in_use[find_slot] &&
                      (refs[find_slot] == REF_ZERO) && has_page[find_slot];
  assign put_idx    = IDX_W'(slot_q);
  assign put_bad    = (32'(slot_q) >= NUM_SLOTS) || (refs[put_idx] == REF_ZERO);

  assign idle      = (state == S_IDLE);
  assign res_valid = (state == S_DONE);
  assign wr_tag    = (state == S_RESOLVE) && !found && vic;
  assign wr_idx    = vic_idx;

  always_ff @(posedge clk) begin
    if (wr_tag) begin
      tag[wr_idx] <= blk_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      valid    <= '0;
      in_use   <= '0;
      has_page <= '0;
      for (int j = 0; j < NUM_SLOTS; j++) begin
        refs[j] <= REF_ZERO;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            blk_q   <= block_id;
            slot_q  <= slot;
            limit_q <= free_limit;
            found   <= 1'b0;
            vic     <= 1'b0;
            res     <= '0;
            unique case (req_type)
              REQ_GET: begin
                idx   <= '0;
                state <= S_SCAN;
              end
              REQ_PUT: begin
                state <= S_PUT;
              end
              REQ_FREE: begin
                idx   <= IDX_LAST;
                state <= S_FREE;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (!found && tag_match) begin
            found     <= 1'b1;
            found_idx <= idx;
          end
          if (vic_better) begin
            vic     <= 1'b1;
            vic_idx <= idx;
            best    <= rd_rank;
          end
          if (idx == IDX_LAST) begin
            state <= S_RESOLVE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_RESOLVE: begin
          if (found) begin
            res.hit      <= 1'b1;
            res.slot_out <= 4'(found_idx);
            if (refs[found_idx] == REF_MAX) begin
              res.status <= ST_OVERFLOW;
              state      <= S_DONE;
            end else begin
              refs[found_idx]   <= refs[found_idx] + 1'b1;
              in_use[found_idx] <= 1'b1;
              nw_slot           <= found_idx;
              state             <= S_NEWEST;
            end
          end else if (!vic) begin
            res.status <= ST_NO_BUF;
            state      <= S_DONE;
          end else begin
            res.slot_out      <= 4'(vic_idx);
            res.need_page     <= !has_page[vic_idx];
            res.need_read     <= 1'b1;
            has_page[vic_idx] <= 1'b1;
            valid[vic_idx]    <= 1'b1;
            refs[vic_idx]     <= REF_ONE;
            in_use[vic_idx]   <= 1'b1;
            nw_slot           <= vic_idx;
            state             <= S_NEWEST;
          end
        end
        S_PUT: begin
          res.slot_out <= slot_q;
          if (put_bad) begin
            res.status <= ST_UNDERFLOW;
            state      <= S_DONE;
          end else begin
            refs[put_idx] <= refs[put_idx] - 1'b1;
            if (refs[put_idx] == REF_ONE) begin
              in_use[put_idx] <= 1'b0;
              nw_slot         <= put_idx;
              state           <= S_NEWEST;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_FREE: begin
          if (free_ok) begin
            has_page[find_slot]       <= 1'b0;
            valid[find_slot]          <= 1'b0;
            limit_q                   <= limit_q - 1'b1;
            res.drop_count            <= res.drop_count + 1'b1;
            res.freed_mask[find_slot] <= 1'b1;
          end
          if (idx == '0) begin
            state <= S_DONE;
          end else begin
            idx <= idx - 1'b1;
          end
        end
        S_NEWEST: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== design/bbc_checker.sv =====
// Port checker for the block buffer cache directory, bound to the top level.
// Depends on bbc_pkg and block_buffer_cache_lru_top.
module bbc_checker import bbc_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic [3:0]  slot_out,
  input logic        hit,
  input logic        need_page,
  input logic        need_read,
  input logic [4:0]  drop_count,
  input logic [15:0] freed_mask
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(slot_out) &&
      $stable(freed_mask))
    else $error("Result item changed while stalled.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("Second item taken while the first is in progress.");

  a_hit_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> !need_read && !need_page && drop_count == 5'd0 &&
      (status == ST_OK || status == ST_OVERFLOW))
    else $error("Hit result carries miss or free fields.");

  a_freed_mask: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $countones(freed_mask) == 32'(drop_count))
    else $error("Freed mask does not match the drop count.");

  a_no_buf: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_NO_BUF |-> slot_out == 4'd0 && !hit && !need_read)
    else $error("No-buffer result names a slot.");

endmodule

bind block_buffer_cache_lru_top bbc_checker u_bbc_checker (.*);
